// ===== src/psu_pkg.sv =====
package psu_pkg;

	// Payload widths fixed by the byte stream format
	localparam int COL_W      = 16;
	localparam int SLOT_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Depth of the queue between the classifier and the reconstruction stage
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_PIXEL   = 2'd0;
	localparam logic [1:0] ST_BADTYPE = 2'd1;
	localparam logic [1:0] ST_SHORT   = 2'd2;

	// Filter types
	localparam logic [2:0] FLT_NONE  = 3'd0;
	localparam logic [2:0] FLT_SUB   = 3'd1;
	localparam logic [2:0] FLT_UP    = 3'd2;
	localparam logic [2:0] FLT_AVG   = 3'd3;
	localparam logic [2:0] FLT_PAETH = 3'd4;

	// One classified item handed from the front part to the back part
	typedef struct packed {
		logic [7:0]        data;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] slot;
		logic              first_row;
		logic              has_left;
		logic [2:0]        filter;
		logic [1:0]        status;
		logic              last;
		logic              short_after;
	} task_t;

endpackage

// ===== src/psu_in_if.sv =====
interface psu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== src/psu_out_if.sv =====
interface psu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] value;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output value, output status, output last, input ready);
	modport sink (input valid, input value, input status, input last, output ready);
endinterface

// ===== src/png_scanline_unfilter.sv =====
// PNG scanline reconstruction for filter types None, Sub, Up, Average and Paeth.
// in_ch carries the decompressed stream one byte per item with an end_of_data
// mark; the first byte of every row is its filter type. out_ch gives one raw
// byte per data byte, with last set on the image's final byte. An unknown type
// gives a status 1 result, data ending early a status 2 result; both carry last
// and value zero, after which bytes are dropped up to end_of_data.
// Registers (cfg_we, cfg_idx, cfg_wdata): 0 width in pixels, 1 height in rows,
// 2 bytes per pixel. Write them only while the block is idle.
// Throughput: one byte per cycle while the receiver is ready and no slot rebuild is
// pending. A data byte's result passes through the queue, then the stage where the
// prior row store read is registered, then the reconstruction adder and Paeth compare
// into the output register. A data byte that also ends the data early gives two results.
// After each register write the input stalls while the serial remainder unit rebuilds
// the pixel slot position.
// Reset clears all control state and the recent-pixel registers; the prior row
// store needs no clearing. When the receiver stalls, the output holds, the
// four-entry queue fills and then in_ch.ready drops.
module png_scanline_unfilter #(
	parameter int MAX_LINE_BYTES = 16384,
	parameter int MAX_BPP        = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_wdata,
	psu_in_if.sink                         in_ch,
	psu_out_if.source                      out_ch
);
	import psu_pkg::*;

	logic  push;
	logic  full;
	logic  pop;
	logic  empty;
	task_t push_task;
	task_t head;

	// Classify items and keep the stream position
	psu_front #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES),
		.MAX_BPP        (MAX_BPP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.push      (push),
		.push_task (push_task),
		.full      (full)
	);

	// Decouple the two sides
	psu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_task (push_task),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// Reconstruct bytes against the prior row
	psu_back #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES),
		.MAX_BPP        (MAX_BPP)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status != ST_PIXEL) |-> out_ch.last && (out_ch.value == 8'd0))
		else $error("error result without last or with nonzero value");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("item pushed into a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("item popped from an empty queue");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ch.ready)
		else $error("input taken before slot position rebuilt");

endmodule

// ===== src/psu_front.sv =====
module psu_front #(
	parameter int MAX_LINE_BYTES = 16384,
	parameter int MAX_BPP        = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	psu_in_if.sink                          in_ch,
	output logic                            push,
	output psu_pkg::task_t                  push_task,
	input  logic                            full
);
	import psu_pkg::*;

	localparam int CW    = $clog2(MAX_LINE_BYTES);
	localparam int LW    = $clog2(MAX_LINE_BYTES + 1);
	localparam int BW    = $clog2(MAX_BPP + 1);
	localparam int SW    = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
	localparam int CNT_W = $clog2(CW + 1);

	typedef enum logic [1:0] {PH_TYPE, PH_DATA, PH_SKIP} phase_t;

	phase_t          phase_q;
	logic [11:0]     w_q;
	logic [15:0]     h_q;
	logic [BW-1:0]   bpp_q;
	logic [LW-1:0]   line_q;
	logic [CW-1:0]   col_q;
	logic [SW-1:0]   slot_q;
	logic [15:0]     row_q;
	logic [2:0]      filter_q;
	logic            mod_load_q;
	logic [CNT_W-1:0] mod_cnt_q;
	logic [CW-1:0]   mod_sh_q;
	logic [BW-1:0]   mod_rem_q;

	logic [11:0]     w_new;
	logic [15:0]     h_new;
	logic [BW-1:0]   b_new;
	logic [11:0]     mul_a;
	logic [BW-1:0]   mul_b;
	logic [15:0]     prod;
	logic [LW-1:0]   line_new;
	logic [CW-1:0]   col_eff;
	logic            row_end;
	logic            image_end;
	logic            has_left;
	logic [SW-1:0]   slot_inc;
	logic [BW:0]     rem_try;
	logic [BW-1:0]   rem_step;
	logic            busy;
	logic            fire;
	logic            eod;

	// Effective register values on a write
	always_comb begin
		w_new = (cfg_wdata[11:0] == 12'd0) ? 12'd1 : cfg_wdata[11:0];
		h_new = (cfg_wdata[15:0] == 16'd0) ? 16'd1 : cfg_wdata[15:0];
		if (cfg_wdata[3:0] == 4'd0) begin
			b_new = BW'(1);
		end else if (32'(cfg_wdata[3:0]) > MAX_BPP) begin
			b_new = BW'(MAX_BPP);
		end else begin
			b_new = BW'(cfg_wdata[3:0]);
		end
		mul_a    = (cfg_idx == CFG_WIDTH) ? w_new : w_q;
		mul_b    = (cfg_idx == CFG_BPP) ? b_new : bpp_q;
		prod     = 16'(mul_a) * 16'(mul_b);
		line_new = (32'(prod) > MAX_LINE_BYTES) ? LW'(MAX_LINE_BYTES) : LW'(prod);
	end

	// Column clamp, row and image end, left neighbour presence
	always_comb begin
		col_eff   = (32'(col_q) >= 32'(line_q)) ? CW'(line_q - LW'(1)) : col_q;
		row_end   = ((LW + 1)'(col_eff) + (LW + 1)'(1)) >= (LW + 1)'(line_q);
		image_end = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, h_q});
		has_left  = 32'(col_eff) >= 32'(bpp_q);
		slot_inc  = (32'(slot_q) + 1 >= 32'(bpp_q)) ? '0 : SW'(slot_q + SW'(1));
	end

	// One restoring step of col mod bpp
	always_comb begin
		rem_try  = {mod_rem_q, mod_sh_q[CW-1]};
		rem_step = (rem_try >= (BW + 1)'(bpp_q)) ? BW'(rem_try - (BW + 1)'(bpp_q))
		                                          : BW'(rem_try);
	end

	assign busy        = mod_load_q || (mod_cnt_q != '0);
	assign in_ch.ready = !full && !busy;
	assign fire        = in_ch.valid && in_ch.ready;
	assign eod         = in_ch.end_of_data;

	// Classify the accepted item and build the task for the back part
	always_comb begin
		push                  = 1'b0;
		push_task             = '0;
		push_task.data        = in_ch.data_byte;
		push_task.col         = COL_W'(col_eff);
		push_task.slot        = SLOT_W'(slot_q);
		push_task.first_row   = (row_q == 16'd0);
		push_task.has_left    = has_left;
		push_task.filter      = filter_q;
		if (fire) begin
			unique case (phase_q)
				PH_TYPE: begin
					if (in_ch.data_byte > 8'(FLT_PAETH)) begin
						push             = 1'b1;
						push_task.status = ST_BADTYPE;
						push_task.last   = 1'b1;
					end else if (eod) begin
						push             = 1'b1;
						push_task.status = ST_SHORT;
						push_task.last   = 1'b1;
					end
				end
				PH_DATA: begin
					push                  = 1'b1;
					push_task.status      = ST_PIXEL;
					push_task.last        = image_end;
					push_task.short_after = eod && !image_end;
				end
				PH_SKIP: ;
				default: ;
			endcase
		end
	end

	// Hold configuration, stream position and the slot recompute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			w_q        <= 12'd1;
			h_q        <= 16'd1;
			bpp_q      <= BW'(1);
			line_q     <= LW'(1);
			col_q      <= '0;
			slot_q     <= '0;
			row_q      <= '0;
			filter_q   <= FLT_NONE;
			mod_load_q <= 1'b0;
			mod_cnt_q  <= '0;
			mod_sh_q   <= '0;
			mod_rem_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_WIDTH: begin
						w_q    <= w_new;
						line_q <= line_new;
					end
					CFG_HEIGHT: h_q <= h_new;
					CFG_BPP: begin
						bpp_q  <= b_new;
						line_q <= line_new;
					end
					default: ;
				endcase
				mod_load_q <= 1'b1;
			end else if (mod_load_q) begin
				mod_load_q <= 1'b0;
				mod_sh_q   <= col_eff;
				mod_rem_q  <= '0;
				mod_cnt_q  <= CNT_W'(CW);
			end else if (mod_cnt_q != '0) begin
				mod_sh_q  <= mod_sh_q << 1;
				mod_rem_q <= rem_step;
				mod_cnt_q <= mod_cnt_q - CNT_W'(1);
				if (mod_cnt_q == CNT_W'(1)) begin
					slot_q <= SW'(rem_step);
				end
			end

			if (fire) begin
				unique case (phase_q)
					PH_TYPE: begin
						if (in_ch.data_byte > 8'(FLT_PAETH)) begin
							if (eod) begin
								col_q <= '0;
								slot_q <= '0;
								row_q <= '0;
								phase_q <= PH_TYPE;
							end else begin
								phase_q <= PH_SKIP;
							end
						end else if (eod) begin
							col_q   <= '0;
							slot_q  <= '0;
							row_q   <= '0;
							phase_q <= PH_TYPE;
						end else begin
							filter_q <= in_ch.data_byte[2:0];
							col_q    <= '0;
							slot_q   <= '0;
							phase_q  <= PH_DATA;
						end
					end
					PH_DATA: begin
						if (image_end) begin
							phase_q <= PH_SKIP;
						end else if (row_end) begin
							row_q   <= row_q + 16'd1;
							col_q   <= '0;
							slot_q  <= '0;
							phase_q <= PH_TYPE;
						end else begin
							col_q  <= col_eff + CW'(1);
							slot_q <= slot_inc;
						end
						// End of data restarts in every case
						if (eod) begin
							col_q   <= '0;
							slot_q  <= '0;
							row_q   <= '0;
							phase_q <= PH_TYPE;
						end
					end
					PH_SKIP: begin
						if (eod) begin
							col_q   <= '0;
							slot_q  <= '0;
							row_q   <= '0;
							phase_q <= PH_TYPE;
						end
					end
					default: phase_q <= PH_TYPE;
				endcase
			end
		end
	end

endmodule

// ===== src/psu_queue.sv =====
module psu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  psu_pkg::task_t push_task,
	output logic           full,
	input  logic           pop,
	output psu_pkg::task_t head,
	output logic           empty
);
	import psu_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	task_t         slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full  = (count_q == NW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_task;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : PW'(wr_ptr_q + PW'(1));
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : PW'(rd_ptr_q + PW'(1));
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// ===== src/psu_back.sv =====
module psu_back #(
	parameter int MAX_LINE_BYTES = 16384,
	parameter int MAX_BPP        = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  psu_pkg::task_t head,
	input  logic           empty,
	output logic           pop,
	psu_out_if.source      out_ch
);
	import psu_pkg::*;

	localparam int CW = $clog2(MAX_LINE_BYTES);
	localparam int SW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

	logic [7:0] line_mem [MAX_LINE_BYTES];
	logic [7:0] recent_raw_q [MAX_BPP];
	logic [7:0] recent_above_q [MAX_BPP];

	task_t      task_s1;
	logic       valid_s1;
	logic [7:0] above_rd_s1;
	logic       fwd_s1;
	logic [7:0] fwd_raw_s1;

	logic       out_valid_q;
	logic [7:0] value_q;
	logic [1:0] status_q;
	logic       last_q;

	logic       advance;
	logic       write_px;
	logic [7:0] above;
	logic [7:0] left;
	logic [7:0] upleft;
	logic [7:0] pred;
	logic [7:0] raw;
	logic [8:0] avg_sum;
	logic [SW-1:0] slot;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
	                                     input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] ds;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		ds = da + db;
		pa = (da < 0) ? 10'(-da) : 10'(da);
		pb = (db < 0) ? 10'(-db) : 10'(db);
		pc = (ds < 0) ? 10'(-ds) : 10'(ds);
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end
		return c;
	endfunction

	assign advance  = valid_s1 && (!out_valid_q || out_ch.ready);
	assign write_px = advance && (task_s1.status == ST_PIXEL);
	assign pop      = !empty && (!valid_s1 || (advance && !task_s1.short_after));
	assign slot     = SW'(task_s1.slot);

	// Gather neighbours; forward the byte just written when the addresses meet
	always_comb begin
		if (task_s1.first_row) begin
			above = 8'd0;
		end else if (fwd_s1) begin
			above = fwd_raw_s1;
		end else begin
			above = above_rd_s1;
		end
		left    = task_s1.has_left ? recent_raw_q[slot] : 8'd0;
		upleft  = task_s1.has_left ? recent_above_q[slot] : 8'd0;
		avg_sum = {1'b0, left} + {1'b0, above};
		case (task_s1.filter)
			FLT_SUB:   pred = left;
			FLT_UP:    pred = above;
			FLT_AVG:   pred = avg_sum[8:1];
			FLT_PAETH: pred = paeth(left, above, upleft);
			default:   pred = 8'd0;
		endcase
		raw = task_s1.data + pred;
	end

	// Prior row store: write the finished byte, prefetch the next item's above byte
	always_ff @(posedge clk) begin
		if (write_px) begin
			line_mem[task_s1.col[CW-1:0]] <= raw;
		end
		if (pop) begin
			above_rd_s1 <= line_mem[head.col[CW-1:0]];
		end
	end

	// Recent raw and above bytes, one per slot of the pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BPP; i++) begin
				recent_raw_q[i]   <= 8'd0;
				recent_above_q[i] <= 8'd0;
			end
		end else if (write_px) begin
			recent_raw_q[slot]   <= raw;
			recent_above_q[slot] <= above;
		end
	end

	// Stage payload: load from the queue, or turn into the early-end result
	always_ff @(posedge clk) begin
		if (pop) begin
			task_s1    <= head;
			fwd_s1     <= write_px && (head.col == task_s1.col);
			fwd_raw_s1 <= raw;
		end else if (advance && task_s1.short_after) begin
			task_s1.status      <= ST_SHORT;
			task_s1.last        <= 1'b1;
			task_s1.short_after <= 1'b0;
		end
		if (advance) begin
			value_q  <= (task_s1.status == ST_PIXEL) ? raw : 8'd0;
			status_q <= task_s1.status;
			last_q   <= task_s1.last;
		end
	end

	// Stage and output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (advance && !task_s1.short_after) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.value  = value_q;
	assign out_ch.status = status_q;
	assign out_ch.last   = last_q;

endmodule

// ===== tb/png_scanline_unfilter_tb.sv =====
module png_scanline_unfilter_tb;

	import psu_pkg::*;

	localparam int LINE_CAP      = 16384;
	localparam int BPP_CAP       = 8;
	localparam int SETTLE_CYCLES = 12;
	localparam int TAIL_CYCLES   = 20;
	localparam int RANDOM_ITEMS  = 400;
	localparam int CALM_ITEMS    = 60;
	localparam int CYCLE_LIMIT   = 4000000;

	typedef struct packed {
		logic [7:0] value;
		logic [1:0] status;
		logic       last;
	} pix_result_t;

	// Up to two results per input byte
	typedef struct packed {
		logic [1:0]  count;
		pix_result_t first;
		pix_result_t second;
	} byte_outcome_t;

	typedef enum logic [1:0] {AWAIT_TYPE, IN_ROW, DROPPING} parse_state_t;
	typedef enum logic [1:0] {ROW_BYTE, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  data;
		logic        eod;
		row_check_t  check;
		pix_result_t typed;
		logic [11:0] w;
		logic [15:0] h;
		logic [3:0]  bpp;
	} step_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	psu_in_if  in_ch();
	psu_out_if out_ch();

	png_scanline_unfilter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// Reconstruction state kept alongside the block
	logic [7:0]   line_store [0:LINE_CAP-1];
	logic [7:0]   left_raw [0:BPP_CAP-1];
	logic [7:0]   left_above [0:BPP_CAP-1];
	int           col_pos;
	int           row_pos;
	logic [2:0]   row_flt;
	parse_state_t parse_state;
	int           reg_width;
	int           reg_height;
	int           reg_bpp;

	pix_result_t awaited_results [$];
	step_row_t   directed_steps [0:26];

	int fails;
	int results_checked;
	int bytes_sent;
	int cfg_writes;
	int live_items;
	int cycle_count;
	int sink_hold;
	int sink_quiet;
	int src_quiet;
	bit src_up;
	bit calm;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int eff_bpp();
		int b;
		b = reg_bpp;
		if (b == 0) b = 1;
		if (b > BPP_CAP) b = BPP_CAP;
		return b;
	endfunction

	function automatic int eff_line();
		int w;
		int n;
		w = (reg_width == 0) ? 1 : reg_width;
		n = w * eff_bpp();
		return (n > LINE_CAP) ? LINE_CAP : n;
	endfunction

	function automatic int eff_height();
		return (reg_height == 0) ? 1 : reg_height;
	endfunction

	// Pick the neighbour nearest to left + above - upper-left, ties to left then above
	function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		int p;
		int da;
		int db;
		int dc;
		p  = int'(a) + int'(b) - int'(c);
		da = p - int'(a);
		db = p - int'(b);
		dc = p - int'(c);
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) return a;
		if (db <= dc) return b;
		return c;
	endfunction

	function automatic void restart_image();
		col_pos     = 0;
		row_pos     = 0;
		parse_state = AWAIT_TYPE;
	endfunction

	// Advance the reconstruction by one accepted byte and return its results
	function automatic byte_outcome_t unfilter_byte(logic [7:0] b, logic eod);
		byte_outcome_t oc;
		int            bpp;
		int            line;
		int            col;
		int            slot;
		logic [7:0]    left;
		logic [7:0]    above;
		logic [7:0]    upleft;
		logic [7:0]    pred;
		logic [7:0]    raw;
		logic          row_end;
		logic          image_end;
		oc = '0;
		if (parse_state == DROPPING) begin
			if (eod) restart_image();
			return oc;
		end
		if (parse_state == AWAIT_TYPE) begin
			if (b > 8'(FLT_PAETH)) begin
				oc.count = 2'd1;
				oc.first = '{8'h00, ST_BADTYPE, 1'b1};
				if (eod) restart_image();
				else parse_state = DROPPING;
				return oc;
			end
			if (eod) begin
				oc.count = 2'd1;
				oc.first = '{8'h00, ST_SHORT, 1'b1};
				restart_image();
				return oc;
			end
			row_flt     = b[2:0];
			col_pos     = 0;
			parse_state = IN_ROW;
			return oc;
		end
		bpp  = eff_bpp();
		line = eff_line();
		col  = (col_pos >= line) ? line - 1 : col_pos;
		slot = col % bpp;
		left   = 8'h00;
		upleft = 8'h00;
		above  = (row_pos != 0) ? line_store[col] : 8'h00;
		if (col >= bpp) begin
			left   = left_raw[slot];
			upleft = left_above[slot];
		end
		case (row_flt)
			FLT_SUB:   pred = left;
			FLT_UP:    pred = above;
			FLT_AVG:   pred = 8'((9'(left) + 9'(above)) >> 1);
			FLT_PAETH: pred = paeth_pick(left, above, upleft);
			default:   pred = 8'h00;
		endcase
		raw = b + pred;
		left_raw[slot]   = raw;
		left_above[slot] = above;
		line_store[col]  = raw;
		row_end   = (col + 1 >= line);
		image_end = row_end && (row_pos + 1 >= eff_height());
		oc.count = 2'd1;
		oc.first = '{raw, ST_PIXEL, image_end};
		if (image_end) begin
			if (eod) restart_image();
			else parse_state = DROPPING;
			return oc;
		end
		if (row_end) begin
			row_pos     = (row_pos + 1) & 16'hFFFF;
			col_pos     = 0;
			parse_state = AWAIT_TYPE;
		end else begin
			col_pos = col + 1;
		end
		if (eod) begin
			oc.count  = 2'd2;
			oc.second = '{8'h00, ST_SHORT, 1'b1};
			restart_image();
		end
		return oc;
	endfunction

	function automatic step_row_t data_row(logic [7:0] d, logic e);
		return '{ROW_BYTE, d, e, CHK_NONE, '0, 12'd0, 16'd0, 4'd0};
	endfunction

	function automatic step_row_t model_row(logic [7:0] d, logic e);
		return '{ROW_BYTE, d, e, CHK_MODEL, '0, 12'd0, 16'd0, 4'd0};
	endfunction

	function automatic step_row_t typed_row(logic [7:0] d, logic e, logic [7:0] v,
			logic [1:0] st, logic lst);
		return '{ROW_BYTE, d, e, CHK_TYPED, '{v, st, lst}, 12'd0, 16'd0, 4'd0};
	endfunction

	function automatic step_row_t cfg_row(logic [11:0] w, logic [15:0] h, logic [3:0] b);
		return '{ROW_CFG, 8'h00, 1'b0, CHK_NONE, '0, w, h, b};
	endfunction

	// Offer one byte and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic eod, output byte_outcome_t oc);
		in_ch.valid       <= 1'b1;
		in_ch.data_byte   <= b;
		in_ch.end_of_data <= eod;
		src_up = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		if (parse_state != DROPPING) live_items++;
		bytes_sent++;
		oc = unfilter_byte(b, eod);
	endtask

	// Maybe leave the input idle for a short burst
	task automatic source_gap();
		int gap;
		if (!calm) begin
			if (src_quiet > 0) begin
				src_quiet--;
			end else if ($urandom_range(0, 39) == 0) begin
				src_quiet = $urandom_range(20, 80);
			end else if ($urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 14);
				in_ch.valid <= 1'b0;
				src_up = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic eod);
		byte_outcome_t oc;
		send_byte(b, eod, oc);
		if (oc.count >= 2'd1) awaited_results.push_back(oc.first);
		if (oc.count == 2'd2) awaited_results.push_back(oc.second);
		source_gap();
	endtask

	// Hold the input until every expected result is out, then let the pipe settle
	task automatic drain_results();
		if (src_up) begin
			in_ch.valid <= 1'b0;
			src_up = 1'b0;
		end
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input int w, input int h, input int bpp);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_WIDTH;
		cfg_wdata <= CFG_DATA_W'(w & 12'hFFF);
		@(posedge clk);
		cfg_idx   <= CFG_HEIGHT;
		cfg_wdata <= CFG_DATA_W'(h & 16'hFFFF);
		@(posedge clk);
		cfg_idx   <= CFG_BPP;
		cfg_wdata <= CFG_DATA_W'(bpp & 4'hF);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_width  = w & 12'hFFF;
		reg_height = h & 16'hFFFF;
		reg_bpp    = bpp & 4'hF;
		cfg_writes += 3;
	endtask

	// Send one image; cut ends the data early at that byte, bad_row gets an unknown type
	task automatic send_image(input int cut, input int bad_row);
		int   line;
		int   rows;
		int   pos;
		logic eod_now;
		line = eff_line();
		rows = eff_height();
		pos  = 0;
		for (int r = 0; r < rows; r++) begin
			if (r == bad_row) begin
				feed_byte(8'($urandom_range(5, 255)), 1'($urandom_range(0, 1)));
				repeat ($urandom_range(0, 4)) feed_byte(8'($urandom), 1'b0);
				return;
			end
			eod_now = (pos == cut);
			feed_byte(8'($urandom_range(0, 4)), eod_now);
			pos++;
			if (eod_now) return;
			for (int c = 0; c < line; c++) begin
				if (cut < 0) eod_now = (r == rows - 1 && c == line - 1) && $urandom_range(0, 1);
				else eod_now = (pos == cut);
				feed_byte(8'($urandom), eod_now);
				pos++;
				if (eod_now) return;
			end
		end
		// trailing bytes after the image are dropped
		repeat ($urandom_range(0, 3)) feed_byte(8'($urandom), 1'b0);
	endtask

	// Close whatever is open with an end-of-data byte so the next image starts clean
	task automatic close_stream();
		if (!(parse_state == AWAIT_TYPE && row_pos == 0)) feed_byte(8'($urandom), 1'b1);
	endtask

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin : result_check
		pix_result_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result: value %h status %0d last %0b",
						out_ch.value, out_ch.status, out_ch.last);
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				if (out_ch.value !== want.value || out_ch.status !== want.status ||
						out_ch.last !== want.last) begin
					fails++;
					if (fails <= 10)
						$display("result %0d: expected value %h status %0d last %0b, got value %h status %0d last %0b",
							results_checked, want.value, want.status, want.last,
							out_ch.value, out_ch.status, out_ch.last);
				end
			end
		end
	end

	// Stall the receiver in random bursts, with quiet stretches between
	always @(posedge clk) begin
		if (calm) begin
			out_ch.ready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold--;
			out_ch.ready <= 1'b0;
		end else if (sink_quiet > 0) begin
			sink_quiet--;
			out_ch.ready <= 1'b1;
		end else if ($urandom_range(0, 49) == 0) begin
			sink_quiet = $urandom_range(30, 120);
			out_ch.ready <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			sink_hold = $urandom_range(0, 13);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		byte_outcome_t oc;
		int            kind;
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = CFG_WIDTH;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.data_byte   = 8'h00;
		in_ch.end_of_data = 1'b0;
		out_ch.ready      = 1'b0;
		fails = 0; results_checked = 0; bytes_sent = 0; cfg_writes = 0;
		live_items = 0; cycle_count = 0; sink_hold = 0; sink_quiet = 0; src_quiet = 0;
		src_up = 1'b0;
		calm   = 1'b0;

		// Power-on register values and cleared recent pixels
		reg_width  = 1;
		reg_height = 1;
		reg_bpp    = 1;
		row_flt    = FLT_NONE;
		for (int i = 0; i < BPP_CAP; i++) begin
			left_raw[i]   = 8'h00;
			left_above[i] = 8'h00;
		end
		restart_image();

		directed_steps = '{
			data_row(8'(FLT_NONE), 1'b0),
			typed_row(8'hFF, 1'b1, 8'hFF, ST_PIXEL, 1'b1),
			data_row(8'(FLT_SUB), 1'b0),
			typed_row(8'h00, 1'b1, 8'h00, ST_PIXEL, 1'b1),
			data_row(8'(FLT_PAETH), 1'b0),
			typed_row(8'h80, 1'b0, 8'h80, ST_PIXEL, 1'b1),
			data_row(8'h22, 1'b1),
			typed_row(8'h05, 1'b0, 8'h00, ST_BADTYPE, 1'b1),
			data_row(8'h33, 1'b1),
			typed_row(8'hFF, 1'b1, 8'h00, ST_BADTYPE, 1'b1),
			typed_row(8'(FLT_UP), 1'b1, 8'h00, ST_SHORT, 1'b1),
			data_row(8'(FLT_AVG), 1'b0),
			typed_row(8'h7F, 1'b1, 8'h7F, ST_PIXEL, 1'b1),
			cfg_row(12'd2, 16'd2, 4'd1),
			data_row(8'(FLT_SUB), 1'b0),
			model_row(8'h10, 1'b0),
			model_row(8'hF8, 1'b0),
			data_row(8'(FLT_PAETH), 1'b0),
			model_row(8'h05, 1'b0),
			model_row(8'hFB, 1'b0),
			data_row(8'h00, 1'b1),
			data_row(8'(FLT_UP), 1'b0),
			model_row(8'h01, 1'b1),
			data_row(8'(FLT_AVG), 1'b0),
			model_row(8'h80, 1'b0),
			model_row(8'hFF, 1'b0),
			typed_row(8'(FLT_NONE), 1'b1, 8'h00, ST_SHORT, 1'b1)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		for (int i = 0; i < $size(directed_steps); i++) begin
			if (directed_steps[i].kind == ROW_CFG) begin
				write_config(int'(directed_steps[i].w), int'(directed_steps[i].h),
					int'(directed_steps[i].bpp));
			end else begin
				send_byte(directed_steps[i].data, directed_steps[i].eod, oc);
				case (directed_steps[i].check)
					CHK_TYPED: awaited_results.push_back(directed_steps[i].typed);
					CHK_MODEL: begin
						if (oc.count >= 2'd1) awaited_results.push_back(oc.first);
						if (oc.count == 2'd2) awaited_results.push_back(oc.second);
					end
					default: ;
				endcase
				source_gap();
			end
		end

		// Largest legal size: short runs into the first row, all ended early
		write_config(2048, 65535, 8);
		repeat (4) begin
			feed_byte(8'($urandom_range(0, 4)), 1'b0);
			repeat ($urandom_range(0, 23)) feed_byte(8'($urandom), 1'b0);
			feed_byte(8'($urandom), 1'b1);
		end

		// Zero registers fall back to one pixel, one row, one byte
		write_config(0, 0, 0);
		repeat (4) begin
			send_image(-1, -1);
			close_stream();
		end

		// Register maxima clamp the pixel size and row length; end the row early
		write_config(4095, 1, 15);
		send_image($urandom_range(8, 40), -1);
		close_stream();

		// Random phases: mostly well-formed images, some cut short, some broken
		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				write_config($urandom_range(8, 24), $urandom_range(1, 2), 1);
			else
				write_config($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 8));
			repeat ($urandom_range(3, 6)) begin
				if (live_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
				kind = $urandom_range(0, 9);
				if (kind <= 6)
					send_image(-1, -1);
				else if (kind == 7)
					send_image($urandom_range(0, eff_height() * (eff_line() + 1) - 2), -1);
				else if (kind == 8)
					send_image(-1, $urandom_range(0, eff_height() - 1));
				else
					repeat ($urandom_range(1, 12))
						feed_byte(8'($urandom), $urandom_range(0, 3) == 0);
				close_stream();
			end
		end

		// Let the last results out, then watch for strays
		if (src_up) begin
			in_ch.valid <= 1'b0;
			src_up = 1'b0;
		end
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d bytes after %0d register writes",
			results_checked, bytes_sent, cfg_writes);
		$display("Covered all filter types, bad types, early ends and row-length extremes");
		if (fails == 0 && awaited_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
